FILE: sv/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Shared widths, constants and side-band types of the triangle normal core.
// ----------------------------------------------------------------------------
package tun_pkg;

    localparam int COORD_W     = 16;              // vertex and reference fields
    localparam int EDGE_W      = COORD_W + 1;     // vertex difference
    localparam int PROD_W      = 2 * EDGE_W;      // edge component product
    localparam int CROSS_W     = PROD_W + 1;      // signed cross component
    localparam int MAG_W       = CROSS_W - 1;     // cross magnitude
    localparam int POS_W       = 6;               // msb position of a magnitude
    localparam int NORM_W      = 24;              // normalized magnitude
    localparam int NORM_TOP    = NORM_W - 1;
    localparam int SQR_W       = 2 * NORM_W;
    localparam int SUM_W       = SQR_W + 2;
    localparam int RAD_SHIFT   = 12;
    localparam int RAD_W       = SUM_W + RAD_SHIFT; // radicand, 62 bits
    localparam int SQRT_STAGES = RAD_W / 2;         // one root bit per stage
    localparam int ROOT_W      = SQRT_STAGES;
    localparam int NUM_SHIFT   = 20;
    localparam int NUM_W       = NORM_W + NUM_SHIFT + 1;
    localparam int QUO_W       = 16;                // one quotient bit per stage
    localparam int CMP_W       = NUM_W + 2;
    localparam int DOT_W       = 54;
    localparam int SPLIT       = 17;                // low part of a cross component

    localparam logic [QUO_W-1:0] UNIT_ONE = QUO_W'(16384);

    // Payload that rides along the square-root pipeline.
    typedef struct packed {
        logic [2:0][NORM_W-1:0] d;
        logic [2:0]             neg;
        logic                   degen;
    } t_side;

    // Payload of one divider lane.
    typedef struct packed {
        logic neg;
        logic degen;
    } t_dside;

endpackage

FILE: sv/triangle_unit_normal_core.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal_core
// Unit normal of a triangle in Q1.14, oriented by a reference direction.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one item per triangle, tdata holds first/second/third
//   vertex x,y,z and ref x,y,z, 16 bits each, first_x in the lowest bits.
//   Output stream: tdata holds unit_x,y,z (Q1.14), tuser the degenerate flag.
//   Degenerate triangles (zero cross product) come out as a zero vector.
// Throughput: one item per cycle while the output is not stalled, no dependency between items.
// Depth: most of the pipeline is the square root (31 stages, one root bit
//   each) and the three divider lanes (16 stages, one quotient bit each).
// Stall: all stages move on a common advance; the input is ready whenever
//   the output register is empty or being taken. A stall freezes the whole
//   pipe, nothing is lost or repeated.
// Reset: synchronous, active low; clears all valid bits, data is don't-care.
// ----------------------------------------------------------------------------
module triangle_unit_normal_core
    import tun_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // first_x,y,z, second_x,y,z, third_x,y,z, ref_x,y,z (16 bits each, lsb up)
    input  logic [191:0] i_s_axis_tdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // unit_x, unit_y, unit_z (16 bits each, lsb up)
    output logic [47:0]  o_m_axis_tdata,
    // degenerate
    output logic         o_m_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready
);

    logic w_adv;

    // ---- stage 1: edge vectors ----
    logic                      r1_vld;
    logic signed [EDGE_W-1:0]  r1_e0 [3];
    logic signed [EDGE_W-1:0]  r1_e1 [3];
    logic signed [COORD_W-1:0] r1_ref [3];

    // ---- stage 2: cross partial products ----
    logic                      r2_vld;
    logic signed [PROD_W-1:0]  r2_p [6];
    logic signed [COORD_W-1:0] r2_ref [3];

    // ---- stage 3: cross product ----
    logic                      r3_vld;
    logic signed [CROSS_W-1:0] r3_c [3];
    logic signed [COORD_W-1:0] r3_ref [3];

    // ---- stage 4: dot partials, magnitudes ----
    logic                      r4_vld;
    logic signed [PROD_W-1:0]  r4_ph [3];
    logic signed [PROD_W-1:0]  r4_pl [3];
    logic        [MAG_W-1:0]   r4_mg [3];
    logic        [2:0]         r4_cneg;
    logic                      r4_zero;

    // ---- stage 5: orientation, msb position ----
    logic                      r5_vld;
    logic                      r5_flip;
    logic        [POS_W-1:0]   r5_pos;
    logic        [MAG_W-1:0]   r5_mg [3];
    logic        [2:0]         r5_cneg;
    logic                      r5_zero;

    // ---- stage 6: normalized magnitudes ----
    logic                      r6_vld;
    t_side                     r6_side;

    // ---- stage 7: squares ----
    logic                      r7_vld;
    logic        [SQR_W-1:0]   r7_sq [3];
    t_side                     r7_side;

    // ---- stage 8: radicand ----
    logic                      r8_vld;
    logic        [RAD_W-1:0]   r8_rad;
    t_side                     r8_side;

    // ---- sqrt output and stage 9: dividends ----
    logic                      w_sq_vld;
    logic        [ROOT_W-1:0]  w_root;
    t_side                     w_sq_side;
    logic                      r9_vld;
    logic        [NUM_W-1:0]   r9_num [3];
    logic        [ROOT_W-1:0]  r9_den;
    t_dside                    r9_dside [3];

    // ---- divider outputs and output register ----
    logic                      w_dv_vld [3];
    logic        [QUO_W-1:0]   w_quo [3];
    t_dside                    w_dv_side [3];
    logic                      r_out_vld;
    logic        [47:0]        r_out_data;
    logic                      r_out_degen;

    logic signed [DOT_W-1:0]   w_dot;
    logic        [POS_W-1:0]   w_pos;
    logic        [MAG_W-1:0]   w_max;

    assign w_adv           = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    // valid chain of the stages outside the square root and the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r8_vld    <= 1'b0;
            r9_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld    <= i_s_axis_tvalid;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= r5_vld;
            r7_vld    <= r6_vld;
            r8_vld    <= r7_vld;
            r9_vld    <= w_sq_vld;
            r_out_vld <= w_dv_vld[0];
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r1_e0[i] <= EDGE_W'($signed(i_s_axis_tdata[(3+i)*16 +: 16]))
                          - EDGE_W'($signed(i_s_axis_tdata[i*16 +: 16]));
                r1_e1[i] <= EDGE_W'($signed(i_s_axis_tdata[(6+i)*16 +: 16]))
                          - EDGE_W'($signed(i_s_axis_tdata[(3+i)*16 +: 16]));
                r1_ref[i] <= $signed(i_s_axis_tdata[(9+i)*16 +: 16]);
            end
        end
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_p[0] <= r1_e0[1] * r1_e1[2];
            r2_p[1] <= r1_e0[2] * r1_e1[1];
            r2_p[2] <= r1_e0[2] * r1_e1[0];
            r2_p[3] <= r1_e0[0] * r1_e1[2];
            r2_p[4] <= r1_e0[0] * r1_e1[1];
            r2_p[5] <= r1_e0[1] * r1_e1[0];
            r2_ref  <= r1_ref;
        end
    end

    // stage 3
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r3_c[i] <= CROSS_W'(r2_p[2*i]) - CROSS_W'(r2_p[2*i+1]);
            end
            r3_ref <= r2_ref;
        end
    end

    // stage 4: dot product split into high and low halves of each component
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r4_ph[i]   <= r3_ref[i] * $signed(r3_c[i][CROSS_W-1:SPLIT]);
                r4_pl[i]   <= r3_ref[i] * $signed({1'b0, r3_c[i][SPLIT-1:0]});
                r4_mg[i]   <= r3_c[i][CROSS_W-1] ? MAG_W'(-r3_c[i]) : MAG_W'(r3_c[i]);
                r4_cneg[i] <= r3_c[i][CROSS_W-1];
            end
            r4_zero <= (r3_c[0] == '0) && (r3_c[1] == '0) && (r3_c[2] == '0);
        end
    end

    // stage 5: dot sum and msb search of the largest magnitude
    always_comb begin
        w_dot = '0;
        for (int i = 0; i < 3; i++) begin
            w_dot = w_dot + (DOT_W'(r4_ph[i]) <<< SPLIT) + DOT_W'(r4_pl[i]);
        end
        w_max = r4_mg[0];
        if (r4_mg[1] > w_max) w_max = r4_mg[1];
        if (r4_mg[2] > w_max) w_max = r4_mg[2];
        w_pos = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (w_max[i]) w_pos = POS_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_flip <= !(w_dot > 0);
            r5_pos  <= w_pos;
            r5_mg   <= r4_mg;
            r5_cneg <= r4_cneg;
            r5_zero <= r4_zero;
        end
    end

    // stage 6: common shift puts the largest magnitude in [2^23, 2^24)
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                if (r5_pos > POS_W'(NORM_TOP)) begin
                    r6_side.d[i] <= NORM_W'(r5_mg[i] >> (r5_pos - POS_W'(NORM_TOP)));
                end else begin
                    r6_side.d[i] <= NORM_W'(r5_mg[i] << (POS_W'(NORM_TOP) - r5_pos));
                end
                r6_side.neg[i] <= r5_cneg[i] ^ r5_flip;
            end
            r6_side.degen <= r5_zero;
        end
    end

    // stage 7
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r7_sq[i] <= r6_side.d[i] * r6_side.d[i];
            end
            r7_side <= r6_side;
        end
    end

    // stage 8
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_rad  <= {SUM_W'(r7_sq[0]) + SUM_W'(r7_sq[1]) + SUM_W'(r7_sq[2]),
                        RAD_SHIFT'(0)};
            r8_side <= r7_side;
        end
    end

    tun_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r8_vld),
        .i_rad   (r8_rad),
        .i_side  (r8_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // stage 9: rounded dividend d * 2^20 + r / 2
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r9_num[i]         <= {1'b0, w_sq_side.d[i], NUM_SHIFT'(0)}
                                   + NUM_W'(w_root >> 1);
                r9_dside[i].neg   <= w_sq_side.neg[i];
                r9_dside[i].degen <= w_sq_side.degen;
            end
            r9_den <= w_root;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        tun_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_vld   (r9_vld),
            .i_num   (r9_num[i]),
            .i_den   (r9_den),
            .i_side  (r9_dside[i]),
            .o_vld   (w_dv_vld[i]),
            .o_quo   (w_quo[i]),
            .o_side  (w_dv_side[i])
        );
    end

    // output register: clamp, sign, zero for degenerate
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                logic [QUO_W-1:0] v_q;
                v_q = (w_quo[i] > UNIT_ONE) ? UNIT_ONE : w_quo[i];
                if (w_dv_side[i].degen) begin
                    r_out_data[i*16 +: 16] <= '0;
                end else if (w_dv_side[i].neg) begin
                    r_out_data[i*16 +: 16] <= 16'(-v_q);
                end else begin
                    r_out_data[i*16 +: 16] <= v_q;
                end
            end
            r_out_degen <= w_dv_side[0].degen;
        end
    end

    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_degen;
    assign o_m_axis_tvalid = r_out_vld;

    // ---- assertions ----
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("degenerate item with nonzero normal");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_vld && !w_sq_side.degen |-> w_root[ROOT_W-1] || w_root[ROOT_W-2]
                                         || w_root[ROOT_W-3])
        else $error("root below normalized range");

    a_lane_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv_vld[0] == w_dv_vld[1] && w_dv_vld[1] == w_dv_vld[2])
        else $error("divider lanes out of step");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r9_den) && $stable(r_out_data))
        else $error("pipeline moved during stall");

endmodule

FILE: sv/tun_sqrt.sv
// ----------------------------------------------------------------------------
// tun_sqrt
// Pipelined integer square root, one result bit resolved per stage.
// ----------------------------------------------------------------------------
module tun_sqrt
    import tun_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [RAD_W-1:0]  i_rad,
    input  t_side             i_side,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    logic              r_vld  [SQRT_STAGES];
    logic [RAD_W-1:0]  r_rem  [SQRT_STAGES-1];
    logic [RAD_W-1:0]  r_res  [SQRT_STAGES];
    t_side             r_side [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQRT_STAGES - 1 - k));
        logic             w_vld;
        logic [RAD_W-1:0] w_rem;
        logic [RAD_W-1:0] w_res;
        logic [RAD_W-1:0] w_try;
        t_side            w_side;

        if (k == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_rem  = i_rad;
            assign w_res  = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_res  = r_res[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_try = w_res + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= w_side;
                if (w_rem >= w_try) begin
                    r_res[k] <= (w_res >> 1) + BIT;
                end else begin
                    r_res[k] <= w_res >> 1;
                end
            end
        end

        // the last stage needs no remainder
        if (k < SQRT_STAGES - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= (w_rem >= w_try) ? w_rem - w_try : w_rem;
                end
            end
        end
    end

    assign o_vld  = r_vld[SQRT_STAGES-1];
    assign o_root = r_res[SQRT_STAGES-1][ROOT_W-1:0];
    assign o_side = r_side[SQRT_STAGES-1];

endmodule

FILE: sv/tun_div.sv
// ----------------------------------------------------------------------------
// tun_div
// Pipelined restoring divider, one quotient bit per stage, msb first.
// ----------------------------------------------------------------------------
module tun_div
    import tun_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [ROOT_W-1:0] i_den,
    input  t_dside            i_side,
    output logic              o_vld,
    output logic [QUO_W-1:0]  o_quo,
    output t_dside            o_side
);

    logic              r_vld  [QUO_W];
    logic [NUM_W-1:0]  r_rem  [QUO_W-1];
    logic [ROOT_W-1:0] r_den  [QUO_W-1];
    logic [QUO_W-1:0]  r_quo  [QUO_W];
    t_dside            r_side [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic              w_vld;
        logic [NUM_W-1:0]  w_rem;
        logic [ROOT_W-1:0] w_den;
        logic [QUO_W-1:0]  w_quo;
        t_dside            w_side;
        logic [CMP_W-1:0]  w_dsh;
        logic              w_take;

        if (k == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_rem  = i_num;
            assign w_den  = i_den;
            assign w_quo  = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_den  = r_den[k-1];
            assign w_quo  = r_quo[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_dsh  = CMP_W'(w_den) << (QUO_W - 1 - k);
        assign w_take = CMP_W'(w_rem) >= w_dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k]  <= {w_quo[QUO_W-2:0], w_take};
                r_side[k] <= w_side;
            end
        end

        if (k < QUO_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_take ? w_rem - w_dsh[NUM_W-1:0] : w_rem;
                    r_den[k] <= w_den;
                end
            end
        end
    end

    assign o_vld  = r_vld[QUO_W-1];
    assign o_quo  = r_quo[QUO_W-1];
    assign o_side = r_side[QUO_W-1];

endmodule

FILE: test/triangle_unit_normal_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_unit_normal_core_tb
// Self-checking bench for the triangle unit normal core. A directed table of
// triangles (extremes, degenerate, zero and negative orientation) is followed
// by random triangles; each item's normal is predicted in the bench and
// compared field by field with the output stream, under random idling on
// both sides, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module triangle_unit_normal_core_tb;

    localparam int LATENCY  = 57;
    localparam int WD_LIMIT = 20000;
    localparam int N_RANDOM = 1080;
    localparam int HOLD_AT  = 20;       // items in flight before the hold-off

    typedef struct packed {
        logic [15:0] rz, ry, rx;
        logic [15:0] tz, ty, tx;
        logic [15:0] sz, sy, sx;
        logic [15:0] fz, fy, fx;
    } t_tri;

    typedef struct packed {
        logic [15:0] ux, uy, uz;
        logic        degen;
    } t_normal;

    typedef struct {
        t_tri    tri_in;
        bit      typed;    // expected value given in the table
        t_normal nrm;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic [191:0] i_s_axis_tdata;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [47:0]  o_m_axis_tdata;
    logic         o_m_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;

    triangle_unit_normal_core dut (.*);

    t_normal normal_q[$];
    int      n_mismatch;
    int      idle_cycles;
    int      send_idle_pct, recv_idle_pct;
    bit      hold_off;
    bit      stim_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // integer square root, bit by bit
    function automatic logic [63:0] root64(logic [63:0] n);
        logic [63:0] res, bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // unit normal of one triangle, oriented toward the reference side
    function automatic t_normal unit_normal(t_tri t);
        longint      e0[3], e1[3], c[3], rf[3];
        longint      dot;
        logic [63:0] mg[3], d[3], m, sum, r, q;
        logic [15:0] u[3];
        bit          flip, left;
        int          s;
        t_normal     o;
        e0[0] = longint'($signed(t.sx)) - longint'($signed(t.fx));
        e0[1] = longint'($signed(t.sy)) - longint'($signed(t.fy));
        e0[2] = longint'($signed(t.sz)) - longint'($signed(t.fz));
        e1[0] = longint'($signed(t.tx)) - longint'($signed(t.sx));
        e1[1] = longint'($signed(t.ty)) - longint'($signed(t.sy));
        e1[2] = longint'($signed(t.tz)) - longint'($signed(t.sz));
        rf[0] = longint'($signed(t.rx));
        rf[1] = longint'($signed(t.ry));
        rf[2] = longint'($signed(t.rz));
        c[0] = e0[1] * e1[2] - e0[2] * e1[1];
        c[1] = e0[2] * e1[0] - e0[0] * e1[2];
        c[2] = e0[0] * e1[1] - e0[1] * e1[0];
        if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
            o.ux = '0; o.uy = '0; o.uz = '0; o.degen = 1'b1;
            return o;
        end
        dot  = rf[0] * c[0] + rf[1] * c[1] + rf[2] * c[2];
        flip = !(dot > 0);
        m = '0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = (c[i] < 0) ? -c[i] : c[i];
            if (mg[i] > m) m = mg[i];
        end
        s = 0;
        left = (m < (64'd1 << 24));
        if (!left) begin
            while ((m >> s) >= (64'd1 << 24)) s++;
        end else begin
            while ((m << s) < (64'd1 << 23)) s++;
        end
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            d[i] = left ? (mg[i] << s) : (mg[i] >> s);
            sum += d[i] * d[i];
        end
        r = root64(sum << 12);
        for (int i = 0; i < 3; i++) begin
            q = ((d[i] << 20) + (r >> 1)) / r;
            if (q > 64'd16384) q = 64'd16384;
            u[i] = 16'((((c[i] < 0) != flip) ? -q : q));
        end
        o.ux = u[0]; o.uy = u[1]; o.uz = u[2]; o.degen = 1'b0;
        return o;
    endfunction

    function automatic t_tri rand_tri();
        t_tri t;
        int   span;
        span = $urandom_range(3);
        t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if (span == 0) begin
            // small triangles near a random point: tiny cross products
            t.sx = t.fx + 16'($urandom_range(6)) - 16'd3;
            t.sy = t.fy + 16'($urandom_range(6)) - 16'd3;
            t.sz = t.fz + 16'($urandom_range(6)) - 16'd3;
            t.tx = t.fx + 16'($urandom_range(6)) - 16'd3;
            t.ty = t.fy + 16'($urandom_range(6)) - 16'd3;
            t.tz = t.fz + 16'($urandom_range(6)) - 16'd3;
        end else if (span == 1) begin
            // references in the Q1.14 range
            t.rx = 16'($urandom_range(32768)) - 16'd16384;
            t.ry = 16'($urandom_range(32768)) - 16'd16384;
            t.rz = 16'($urandom_range(32768)) - 16'd16384;
        end
        if ($urandom_range(19) == 0) begin
            t.tx = t.sx; t.ty = t.sy; t.tz = t.sz;    // collapsed edge
        end
        return t;
    endfunction

    // valid stays high across back-to-back items, drops only while idling
    task automatic send_item(t_tri t);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tdata  <= t;
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // accepted input items enter the expectation store
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            normal_q.push_back(unit_normal(i_s_axis_tdata));
    end

    // output check against the oldest expectation
    always @(posedge i_clk) begin
        t_normal want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (normal_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected item %h", o_m_axis_tdata);
            end else begin
                want = normal_q.pop_front();
                if (o_m_axis_tdata !== {want.uz, want.uy, want.ux}
                        || o_m_axis_tuser !== want.degen) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp %h/%b got %h/%b",
                                 {want.uz, want.uy, want.ux}, want.degen,
                                 o_m_axis_tdata, o_m_axis_tuser);
                end
            end
        end
    end

    // receiver: random stall, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_off) i_m_axis_tready <= 1'b0;
        else          i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("triangle_unit_normal_core_tb: FAIL");
            $finish;
        end
    end

    // long output hold-off while the sender keeps offering; the pipe
    // freezes and the input stalls
    initial begin
        hold_off = 1'b0;
        wait (stim_done == 1'b0 && normal_q.size() > HOLD_AT);
        @(negedge i_clk);
        hold_off = 1'b1;
        repeat (200) @(negedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        t_row table_rows[$];
        t_row row;
        t_normal z;
        int   wait_cnt;
        n_mismatch = 0; idle_cycles = 0; stim_done = 0;
        send_idle_pct = 37; recv_idle_pct = 48;
        i_rst_n = 1'b0; i_s_axis_tvalid = 1'b0; i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        z.ux = '0; z.uy = '0; z.uz = '0; z.degen = 1'b1;

        // directed table
        row.typed = 1; row.nrm = z;
        row.tri_in = '0;                                   table_rows.push_back(row);
        row.tri_in = {12{16'h8000}};                       table_rows.push_back(row);
        row.tri_in = {12{16'h7fff}};                       table_rows.push_back(row);
        // collinear points
        row.tri_in = '0; row.tri_in.sx = 16'd5; row.tri_in.tx = 16'd10;
        table_rows.push_back(row);
        // unit triangle in xy plane, reference +z: normal +z
        row.tri_in = '0; row.tri_in.sx = 16'd1; row.tri_in.ty = 16'd1;
        row.tri_in.rz = 16'd16384;
        row.nrm.ux = '0; row.nrm.uy = '0; row.nrm.uz = 16'd16384; row.nrm.degen = 1'b0;
        table_rows.push_back(row);
        // reference -z: negated
        row.tri_in.rz = 16'hc000; row.nrm.uz = 16'hc000; table_rows.push_back(row);
        // zero dot product (reference in plane): negated
        row.tri_in.rz = '0; row.tri_in.rx = 16'd16384;    table_rows.push_back(row);
        row.typed = 0;
        row.tri_in = {16'h7fff, 16'h8000, 16'h4000, 16'h7fff, 16'h8000, 16'h8000,
                      16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff};
        table_rows.push_back(row);
        row.tri_in = {16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'h0000, 16'h8000,
                      16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h8000, 16'h7fff};
        table_rows.push_back(row);
        row.tri_in = {16'h8000, 16'h7fff, 16'h0001, 16'h0003, 16'h0002, 16'h0001,
                      16'h0001, 16'h0001, 16'h0002, 16'h0000, 16'h0000, 16'h0000};
        table_rows.push_back(row);
        for (int i = 0; i < 10; i++) begin
            row.tri_in = rand_tri();
            table_rows.push_back(row);
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (table_rows[k]) begin
            if (table_rows[k].typed && unit_normal(table_rows[k].tri_in) != table_rows[k].nrm)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("table row %0d: exp %h got %h", k, table_rows[k].nrm,
                             unit_normal(table_rows[k].tri_in));
            end
            send_item(table_rows[k].tri_in);
        end

        // random part in three idling phases
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) begin
                send_idle_pct = 48; recv_idle_pct = 37;
            end else if (i == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end else if (i == N_RANDOM / 2) begin
                // sender pause until drained
                i_s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
                while (normal_q.size() != 0) @(negedge i_clk);
            end
            send_item(rand_tri());
        end
        i_s_axis_tvalid <= 1'b0;
        stim_done = 1;

        wait_cnt = 0;
        while (normal_q.size() != 0 && wait_cnt < WD_LIMIT) begin
            @(negedge i_clk);
            wait_cnt++;
        end
        repeat (LATENCY + 10) @(negedge i_clk);
        if (n_mismatch == 0 && normal_q.size() == 0) begin
            $display("triangle_unit_normal_core_tb: PASS");
        end else begin
            $display("triangle_unit_normal_core_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/tun_pkg.sv
sv/tun_sqrt.sv
sv/tun_div.sv
sv/triangle_unit_normal_core.sv
test/triangle_unit_normal_core_tb.sv
